// ----- rtl/fcce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcce_pkg
// Shared types, widths and codes for the FAT cluster chain engine.
// ----------------------------------------------------------------------------
package fcce_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 65536;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LIM_W       = ADDR_W + 1;

  // Field widths
  localparam int OP_W    = 3;
  localparam int CL_W    = 28;
  localparam int ENT_W   = 32;
  localparam int ST_W    = 2;
  localparam int LEN_W   = 17;
  localparam int CFG_W   = 17;
  localparam int TOP_W   = ENT_W - CL_W;
  localparam int PADDR_W = 3;

  // Entry constants
  localparam logic [CL_W-1:0] EOC_MARK = 28'hFFFFFF8;
  localparam logic [CFG_W-1:0] TABLE_ENTRIES_RST = 17'h10000;

  // Opcodes
  localparam logic [OP_W-1:0] OP_LOAD        = 3'd0;
  localparam logic [OP_W-1:0] OP_READ        = 3'd1;
  localparam logic [OP_W-1:0] OP_WALK        = 3'd2;
  localparam logic [OP_W-1:0] OP_ALLOC_AFTER = 3'd3;
  localparam logic [OP_W-1:0] OP_ALLOC_NEW   = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE  = 2'd2;
  localparam logic [ST_W-1:0] ST_LOOP   = 2'd3;

  // Read address select
  localparam logic [1:0] RD_CL       = 2'd0;  // latched cluster
  localparam logic [1:0] RD_LINK     = 2'd1;  // link held in read data
  localparam logic [1:0] RD_ZERO     = 2'd2;  // first entry of a scan
  localparam logic [1:0] RD_NXT_SCAN = 2'd3;  // next entry of a scan

  // Write select
  localparam logic [1:0] WR_LOAD = 2'd0;  // raw value at cluster
  localparam logic [1:0] WR_LINK = 2'd1;  // link cluster to free entry
  localparam logic [1:0] WR_EOC  = 2'd2;  // end-of-chain at free entry

  // Result kind
  localparam logic [1:0] RES_NONE  = 2'd0;
  localparam logic [1:0] RES_ENTRY = 2'd1;
  localparam logic [1:0] RES_WALK  = 2'd2;
  localparam logic [1:0] RES_ALLOC = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic            load_in;
    logic            rd_en;
    logic [1:0]      rd_sel;
    logic            wr_en;
    logic [1:0]      wr_sel;
    logic            walk_init;
    logic            walk_step;
    logic            scan_init;
    logic            scan_step;
    logic            top_latch;
    logic            done;
    logic [ST_W-1:0] done_status;
    logic [1:0]      done_kind;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            lim_zero;
    logic            cl_oor;
    logic            is_eoc;
    logic            cnt_full;
    logic            nxt_oor;
    logic            ent_zero;
    logic            scan_end;
  } dp_stat_t;

endpackage

// ----- rtl/fcce_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcce_ctrl
// Sequencer for load, read, chain walk and free-entry allocation.
// ----------------------------------------------------------------------------
module fcce_ctrl
  import fcce_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_RD_WAIT = 3'd2;
  localparam logic [2:0] S_WALK    = 3'd3;
  localparam logic [2:0] S_GET_CL  = 3'd4;
  localparam logic [2:0] S_SCAN    = 3'd5;
  localparam logic [2:0] S_WR_LINK = 3'd6;
  localparam logic [2:0] S_WR_EOC  = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign busy = (state_r != S_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.op)
          OP_LOAD: begin
            cmd.done = 1'b1;
            if (stat.cl_oor) begin
              cmd.done_status = ST_RANGE;
            end else begin
              cmd.wr_en       = 1'b1;
              cmd.wr_sel      = WR_LOAD;
              cmd.done_status = ST_OK;
              cmd.done_kind   = RES_NONE;
            end
            state_nxt = S_IDLE;
          end
          OP_READ: begin
            if (stat.cl_oor) begin
              cmd.done        = 1'b1;
              cmd.done_status = ST_RANGE;
              state_nxt       = S_IDLE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_CL;
              state_nxt  = S_RD_WAIT;
            end
          end
          OP_WALK: begin
            if (stat.lim_zero) begin
              cmd.done        = 1'b1;
              cmd.done_status = ST_LOOP;
              state_nxt       = S_IDLE;
            end else if (stat.cl_oor) begin
              cmd.done        = 1'b1;
              cmd.done_status = ST_RANGE;
              state_nxt       = S_IDLE;
            end else begin
              cmd.rd_en     = 1'b1;
              cmd.rd_sel    = RD_CL;
              cmd.walk_init = 1'b1;
              state_nxt     = S_WALK;
            end
          end
          OP_ALLOC_AFTER: begin
            if (stat.cl_oor) begin
              cmd.done        = 1'b1;
              cmd.done_status = ST_RANGE;
              state_nxt       = S_IDLE;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_CL;
              state_nxt  = S_GET_CL;
            end
          end
          OP_ALLOC_NEW: begin
            if (stat.lim_zero) begin
              cmd.done        = 1'b1;
              cmd.done_status = ST_NOFREE;
              state_nxt       = S_IDLE;
            end else begin
              cmd.rd_en     = 1'b1;
              cmd.rd_sel    = RD_ZERO;
              cmd.scan_init = 1'b1;
              state_nxt     = S_SCAN;
            end
          end
          default: begin
            cmd.done        = 1'b1;
            cmd.done_status = ST_RANGE;
            state_nxt       = S_IDLE;
          end
        endcase
      end
      S_RD_WAIT: begin
        cmd.done        = 1'b1;
        cmd.done_status = ST_OK;
        cmd.done_kind   = RES_ENTRY;
        state_nxt       = S_IDLE;
      end
      // One link per cycle: check the entry just read, fetch the next
      S_WALK: begin
        if (stat.is_eoc) begin
          cmd.done        = 1'b1;
          cmd.done_status = ST_OK;
          cmd.done_kind   = RES_WALK;
          state_nxt       = S_IDLE;
        end else if (stat.cnt_full) begin
          cmd.done        = 1'b1;
          cmd.done_status = ST_LOOP;
          state_nxt       = S_IDLE;
        end else if (stat.nxt_oor) begin
          cmd.done        = 1'b1;
          cmd.done_status = ST_RANGE;
          state_nxt       = S_IDLE;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_LINK;
          cmd.walk_step = 1'b1;
        end
      end
      // Keep the top bits of the entry to be linked, then scan
      S_GET_CL: begin
        cmd.top_latch = 1'b1;
        if (stat.lim_zero) begin
          cmd.done        = 1'b1;
          cmd.done_status = ST_NOFREE;
          state_nxt       = S_IDLE;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_ZERO;
          cmd.scan_init = 1'b1;
          state_nxt     = S_SCAN;
        end
      end
      // One entry per cycle from entry zero up
      S_SCAN: begin
        if (stat.ent_zero) begin
          state_nxt = (stat.op == OP_ALLOC_AFTER) ? S_WR_LINK : S_WR_EOC;
        end else if (stat.scan_end) begin
          cmd.done        = 1'b1;
          cmd.done_status = ST_NOFREE;
          state_nxt       = S_IDLE;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_NXT_SCAN;
          cmd.scan_step = 1'b1;
        end
      end
      S_WR_LINK: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_LINK;
        state_nxt  = S_WR_EOC;
      end
      S_WR_EOC: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_sel      = WR_EOC;
        cmd.done        = 1'b1;
        cmd.done_status = ST_OK;
        cmd.done_kind   = RES_ALLOC;
        state_nxt       = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/fcce_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcce_dpath
// Table memory, walk and scan registers, range checks and result registers.
// ----------------------------------------------------------------------------
module fcce_dpath
  import fcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [CL_W-1:0]   in_cluster,
  input  logic [ENT_W-1:0]  in_load_value,
  input  logic [CFG_W-1:0]  table_entries,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  output logic              out_valid,
  output logic [ST_W-1:0]   out_status,
  output logic [CL_W-1:0]   out_result_cluster,
  output logic [ENT_W-1:0]  out_entry_value,
  output logic [LEN_W-1:0]  out_chain_length
);

  logic [ENT_W-1:0]  fat_mem_r [TABLE_DEPTH];
  logic [ENT_W-1:0]  rdata_r;

  logic [OP_W-1:0]   op_r;
  logic [CL_W-1:0]   cl_r;
  logic [ENT_W-1:0]  lv_r;
  logic [ADDR_W-1:0] cur_r;
  logic [LIM_W-1:0]  cnt_r;
  logic [ADDR_W-1:0] sidx_r;
  logic [TOP_W-1:0]  top_r;

  logic              out_valid_r;
  logic [ST_W-1:0]   status_r;
  logic [CL_W-1:0]   res_r;
  logic [ENT_W-1:0]  ent_r;
  logic [LEN_W-1:0]  len_r;

  logic [LIM_W-1:0]  lim;
  logic [CL_W-1:0]   lim_ext;
  logic [LIM_W-1:0]  sidx_inc;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic [ENT_W-1:0]  wr_data;

  // Effective limit, saturated at the table depth
  always_comb begin
    if (32'(table_entries) > 32'(TABLE_DEPTH)) begin
      lim = LIM_W'(TABLE_DEPTH);
    end else begin
      lim = LIM_W'(table_entries);
    end
  end

  assign lim_ext  = CL_W'(lim);
  assign sidx_inc = {1'b0, sidx_r} + LIM_W'(1);

  // Status to the controller
  always_comb begin
    stat.op       = op_r;
    stat.lim_zero = (lim == '0);
    stat.cl_oor   = (cl_r >= lim_ext);
    stat.is_eoc   = (rdata_r[CL_W-1:0] >= EOC_MARK);
    stat.cnt_full = (cnt_r >= lim);
    stat.nxt_oor  = (rdata_r[CL_W-1:0] >= lim_ext);
    stat.ent_zero = (rdata_r == '0);
    stat.scan_end = (sidx_inc >= lim);
  end

  // Address and write data muxes
  always_comb begin
    case (cmd.rd_sel)
      RD_CL:       rd_addr = cl_r[ADDR_W-1:0];
      RD_LINK:     rd_addr = rdata_r[ADDR_W-1:0];
      RD_ZERO:     rd_addr = '0;
      RD_NXT_SCAN: rd_addr = sidx_inc[ADDR_W-1:0];
      default:     rd_addr = '0;
    endcase
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_LOAD: begin
        wr_addr = cl_r[ADDR_W-1:0];
        wr_data = lv_r;
      end
      WR_LINK: begin
        wr_addr = cl_r[ADDR_W-1:0];
        wr_data = {top_r, (CL_W-ADDR_W)'(0), sidx_r};
      end
      WR_EOC: begin
        // a free entry is all zero, so its top bits stay zero
        wr_addr = sidx_r;
        wr_data = {TOP_W'(0), EOC_MARK};
      end
      default: begin
        wr_addr = sidx_r;
        wr_data = lv_r;
      end
    endcase
  end

  // Table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      fat_mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata_r <= fat_mem_r[rd_addr];
    end
  end

  // Item and walk/scan registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r <= in_opcode;
      cl_r <= in_cluster;
      lv_r <= in_load_value;
    end
    if (cmd.walk_init) begin
      cur_r <= cl_r[ADDR_W-1:0];
      cnt_r <= LIM_W'(1);
    end else if (cmd.walk_step) begin
      cur_r <= rdata_r[ADDR_W-1:0];
      cnt_r <= cnt_r + LIM_W'(1);
    end
    if (cmd.scan_init) begin
      sidx_r <= '0;
    end else if (cmd.scan_step) begin
      sidx_r <= sidx_inc[ADDR_W-1:0];
    end
    if (cmd.top_latch) begin
      top_r <= rdata_r[ENT_W-1:CL_W];
    end
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.done;
    end
  end

  // Result payload; every field but status is zero on an error
  always_ff @(posedge clk) begin
    if (cmd.done) begin
      status_r <= cmd.done_status;
      res_r    <= '0;
      ent_r    <= '0;
      len_r    <= '0;
      if (cmd.done_status == ST_OK) begin
        case (cmd.done_kind)
          RES_ENTRY: ent_r <= rdata_r;
          RES_WALK: begin
            res_r <= CL_W'(cur_r);
            len_r <= LEN_W'(cnt_r);
          end
          RES_ALLOC: res_r <= CL_W'(sidx_r);
          default: ;
        endcase
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_result_cluster = res_r;
  assign out_entry_value    = ent_r;
  assign out_chain_length   = len_r;

endmodule

// ----- rtl/fat_cluster_chain_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_cluster_chain_engine
// FAT32 allocation table with load, read, chain walk and allocation.
//
// Channel  | Ports                                   | Transfer
// ---------+-----------------------------------------+---------------------------
// input    | start, busy, in_opcode/cluster/load_val | start high, busy low
// result   | out_valid, out_status/result_cluster/.. | out_valid high, one cycle
// config   | psel, penable, pwrite, paddr, pwdata..  | psel&penable&pwrite&pready
//
// One item at a time; busy stays high until its result strobe.
// Load and early errors: result from the decode state; read: after one table read.
// Walk: follows a chain of N entries, one table read per cycle.
// Allocate (new or after): scans from entry zero to the free index, one read per cycle.
// The table memory has one read and one write port; it is not cleared at reset.
// Reset sets table_entries to 65536; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module fat_cluster_chain_engine
  import fcce_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [CL_W-1:0]    in_cluster,
  input  logic [ENT_W-1:0]   in_load_value,
  // result channel
  output logic               out_valid,
  output logic [ST_W-1:0]    out_status,
  output logic [CL_W-1:0]    out_result_cluster,
  output logic [ENT_W-1:0]   out_entry_value,
  output logic [LEN_W-1:0]   out_chain_length,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [CFG_W-1:0] table_entries_r;
  logic             cfg_wr;
  logic             start_ok;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[PADDR_W-1] == 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_entries_r <= TABLE_ENTRIES_RST;
    end else if (cfg_wr) begin
      table_entries_r <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[PADDR_W-1] == 1'b0) ? 32'(table_entries_r) : 32'd0;

  assign start_ok = start & ~busy;

  fcce_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_ok),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  fcce_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_opcode          (in_opcode),
    .in_cluster         (in_cluster),
    .in_load_value      (in_load_value),
    .table_entries      (table_entries_r),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_result_cluster (out_result_cluster),
    .out_entry_value    (out_entry_value),
    .out_chain_length   (out_chain_length)
  );

endmodule
